// ===== hw/rtl/sprr_pkg.sv =====
// sprr_pkg: shared constants and types for the priority scheduler
// no dependencies
`default_nettype none
package sprr_pkg;
    localparam int NUM_QUEUES_DEF   = 64;
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int HANDLE_WIDTH_DEF = 16;
    localparam int CFG_WIDTH        = 7;
    localparam int PRI_WIDTH        = 16;
    localparam int OUT_HANDLE_WIDTH = 16;
    localparam int OUT_QUEUE_WIDTH  = 6;

    localparam logic ACTION_ENQ = 1'b0;
    localparam logic ACTION_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mem_busy;
    } stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/sprr_if.sv =====
// sprr_if: valid/ready channel carrying one payload word
// depends on nothing
`default_nettype none
interface sprr_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sprr_ram.sv =====
// sprr_ram: generic single write, single read RAM with registered read
// no dependencies
`default_nettype none
module sprr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/sprr_ctrl.sv =====
// sprr_ctrl: controller state machine sequencing one word at a time
// depends on sprr_pkg
`default_nettype none
module sprr_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output sprr_pkg::cmd_t     cmd,
    input  wire sprr_pkg::stat_t stat
);
    sprr_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sprr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sprr_pkg::ST_IDLE:
            begin
                if (in_valid && !stat.mem_busy)
                begin
                    state_next = sprr_pkg::ST_EXEC;
                end
            end
            sprr_pkg::ST_EXEC:
            begin
                state_next = sprr_pkg::ST_RESULT;
            end
            sprr_pkg::ST_RESULT:
            begin
                if (out_ready)
                begin
                    state_next = sprr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sprr_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            sprr_pkg::ST_IDLE:
            begin
                in_ready = !stat.mem_busy;
                cmd.load = in_valid && !stat.mem_busy;
            end
            sprr_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            sprr_pkg::ST_RESULT:
            begin
                out_valid = 1'b1;
                cmd.emit  = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== hw/rtl/sprr_dp.sv =====
// sprr_dp: queue pointer memory, nonempty map, round-robin search and handle store
// depends on sprr_pkg and sprr_ram
`default_nettype none
module sprr_dp #(
    parameter int NUM_QUEUES   = sprr_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH  = sprr_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_WIDTH = sprr_pkg::HANDLE_WIDTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [sprr_pkg::CFG_WIDTH-1:0]        cfg_wdata,
    input  wire logic                                  action,
    input  wire logic                                  tag_present,
    input  wire logic [sprr_pkg::PRI_WIDTH-1:0]        priority_req,
    input  wire logic [HANDLE_WIDTH-1:0]               packet_handle,
    input  wire sprr_pkg::cmd_t                        cmd,
    output sprr_pkg::stat_t                            stat,
    output logic                                       accepted,
    output logic                                       packet_valid,
    output logic [sprr_pkg::OUT_HANDLE_WIDTH-1:0]      out_handle,
    output logic [sprr_pkg::OUT_QUEUE_WIDTH-1:0]       served_queue
);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SD = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW = $clog2(SD);
    localparam int QCW = $clog2(NUM_QUEUES + 1);
    localparam int EW = 2 * PW + CW;

    // nonempty map also marks which pointer memory entries are meaningful
    logic [NUM_QUEUES-1:0] nonempty_reg;
    logic [QW-1:0]         rr_reg;
    logic [sprr_pkg::CFG_WIDTH-1:0] qiu_reg;

    // latched request
    logic                  act_reg;
    logic [QW-1:0]         q_reg, q_next;
    logic                  hit_reg, hit_next;
    logic [HANDLE_WIDTH-1:0] hdl_reg;

    // result register
    logic                  acc_reg;
    logic                  pv_reg;
    logic                  rd_pending_reg;
    logic [QW-1:0]         oq_reg;

    // pointer memory signals
    logic                  ptr_we;
    logic [EW-1:0]         ptr_wdata, ptr_rdata;
    logic [PW-1:0]         cur_head, cur_tail, head_inc, tail_inc;
    logic [CW-1:0]         cur_cnt;
    logic                  enq_ok;

    // store signals
    logic                  st_we;
    logic [AW-1:0]         st_waddr, st_raddr, st_raddr_exec, st_raddr_reg;
    logic [HANDLE_WIDTH-1:0] st_rdata;

    // active queue count, clamped to 1..NUM_QUEUES
    logic [QCW-1:0] n_act;
    always_comb
    begin
        if (qiu_reg == '0)
        begin
            n_act = QCW'(1);
        end
        else if (32'(qiu_reg) > NUM_QUEUES)
        begin
            n_act = QCW'(NUM_QUEUES);
        end
        else
        begin
            n_act = QCW'(qiu_reg);
        end
    end

    // enqueue target queue
    logic [QW-1:0] enq_q;
    always_comb
    begin
        enq_q = '0;
        if (tag_present)
        begin
            if (32'(priority_req) >= 32'(n_act))
            begin
                enq_q = QW'(n_act - QCW'(1));
            end
            else
            begin
                enq_q = QW'(priority_req);
            end
        end
    end

    // rotated find-first-set over queues 1 and up, after the pointer
    logic [QW-1:0] rr_q;
    logic          rr_found;
    always_comb
    begin
        rr_q     = '0;
        rr_found = 1'b0;
        for (int i = NUM_QUEUES - 1; i >= 1; i--)
        begin
            if (nonempty_reg[i] && (i <= 32'(rr_reg)))
            begin
                rr_q     = QW'(i);
                rr_found = 1'b1;
            end
        end
        for (int i = NUM_QUEUES - 1; i >= 1; i--)
        begin
            if (nonempty_reg[i] && (i > 32'(rr_reg)))
            begin
                rr_q     = QW'(i);
                rr_found = 1'b1;
            end
        end
    end

    // queue choice at load; dequeue hit is known here, enqueue room next cycle
    always_comb
    begin
        q_next   = '0;
        hit_next = 1'b0;
        if (action == sprr_pkg::ACTION_ENQ)
        begin
            q_next = enq_q;
        end
        else if (nonempty_reg[0])
        begin
            hit_next = 1'b1;
        end
        else
        begin
            q_next   = rr_q;
            hit_next = rr_found;
        end
    end

    // per-queue head, tail and count, read at load, written back at exec
    sprr_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_QUEUES)
    ) u_ptrs (
        .clk   (clk),
        .we    (ptr_we),
        .waddr (q_reg),
        .wdata (ptr_wdata),
        .raddr (q_next),
        .rdata (ptr_rdata)
    );

    // an empty queue reads as all zero pointers
    always_comb
    begin
        if (nonempty_reg[q_reg])
        begin
            cur_head = ptr_rdata[EW-1 -: PW];
            cur_tail = ptr_rdata[CW +: PW];
            cur_cnt  = ptr_rdata[CW-1:0];
        end
        else
        begin
            cur_head = '0;
            cur_tail = '0;
            cur_cnt  = '0;
        end
        head_inc = (32'(cur_head) == QUEUE_DEPTH - 1) ? '0 : cur_head + PW'(1);
        tail_inc = (32'(cur_tail) == QUEUE_DEPTH - 1) ? '0 : cur_tail + PW'(1);
        enq_ok   = 32'(cur_cnt) < QUEUE_DEPTH;
    end

    // pointer write-back
    always_comb
    begin
        if (act_reg == sprr_pkg::ACTION_ENQ)
        begin
            ptr_we    = cmd.exec && enq_ok;
            ptr_wdata = {cur_head, tail_inc, cur_cnt + CW'(1)};
        end
        else
        begin
            ptr_we    = cmd.exec && hit_reg;
            ptr_wdata = {head_inc, cur_tail, cur_cnt - CW'(1)};
        end
    end

    // store addressing; read address holds after exec so a stalled result keeps its handle
    always_comb
    begin
        st_we         = cmd.exec && (act_reg == sprr_pkg::ACTION_ENQ) && enq_ok;
        st_waddr      = AW'(32'(q_reg) * QUEUE_DEPTH + 32'(cur_tail));
        st_raddr_exec = AW'(32'(q_reg) * QUEUE_DEPTH + 32'(cur_head));
        st_raddr      = cmd.exec ? st_raddr_exec : st_raddr_reg;
    end

    sprr_ram #(
        .WIDTH (HANDLE_WIDTH),
        .DEPTH (SD)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (hdl_reg),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign stat.mem_busy = 1'b0;

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            q_reg   <= q_next;
            hit_reg <= hit_next;
            hdl_reg <= packet_handle;
        end
    end

    // queue state, queues-in-use register and result register update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg   <= '0;
            rr_reg         <= '0;
            qiu_reg        <= sprr_pkg::CFG_WIDTH'(64);
            acc_reg        <= 1'b0;
            pv_reg         <= 1'b0;
            rd_pending_reg <= 1'b0;
            oq_reg         <= '0;
            st_raddr_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                qiu_reg <= cfg_wdata;
            end
            if (cmd.exec)
            begin
                oq_reg         <= q_reg;
                st_raddr_reg   <= st_raddr_exec;
                acc_reg        <= (act_reg == sprr_pkg::ACTION_ENQ) && enq_ok;
                pv_reg         <= (act_reg == sprr_pkg::ACTION_DEQ) && hit_reg;
                rd_pending_reg <= (act_reg == sprr_pkg::ACTION_DEQ) && hit_reg;
                if (act_reg == sprr_pkg::ACTION_ENQ)
                begin
                    if (enq_ok)
                    begin
                        nonempty_reg[q_reg] <= 1'b1;
                    end
                end
                else if (hit_reg)
                begin
                    if (cur_cnt == CW'(1))
                    begin
                        nonempty_reg[q_reg] <= 1'b0;
                    end
                    if (q_reg != '0)
                    begin
                        rr_reg <= q_reg;
                    end
                end
                else
                begin
                    rr_reg <= '0;
                end
            end
            else if (cmd.emit)
            begin
                rd_pending_reg <= 1'b0;
            end
        end
    end

    // result fields, handle comes straight from the registered read
    assign accepted     = acc_reg;
    assign packet_valid = pv_reg;
    assign out_handle   = rd_pending_reg
                        ? sprr_pkg::OUT_HANDLE_WIDTH'(st_rdata) : '0;
    assign served_queue = sprr_pkg::OUT_QUEUE_WIDTH'(oq_reg);
endmodule
`default_nettype wire

// ===== hw/rtl/strict_priority_plus_round_robin_queue.sv =====
// strict_priority_plus_round_robin_queue: top level of the packet scheduler
// depends on sprr_pkg, sprr_ctrl, sprr_dp, sprr_ram
//
// channel   role    payload
// in        sink    action, tag_present, priority_req, packet_handle
// out       source  accepted, packet_valid, out_handle, served_queue
// cfg       write   queues_in_use (cfg_we, cfg_wdata)
//
// each word is handled in order: accept with queue pick and pointer memory read,
// pointer update with the handle store access, then the result
// the registered reads of the pointer memory and the handle store set this sequence
// in.ready stays low from acceptance until the result word is taken
// the result waits in its register while out.ready is low; reset is immediate
`default_nettype none
module strict_priority_plus_round_robin_queue #(
    parameter int NUM_QUEUES   = sprr_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH  = sprr_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_WIDTH = sprr_pkg::HANDLE_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [sprr_pkg::CFG_WIDTH-1:0] cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           in_action,
    input  wire logic                           in_tag_present,
    input  wire logic [sprr_pkg::PRI_WIDTH-1:0] in_priority_req,
    input  wire logic [HANDLE_WIDTH-1:0]        in_packet_handle,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                out_accepted,
    output logic                                out_packet_valid,
    output logic [sprr_pkg::OUT_HANDLE_WIDTH-1:0] out_out_handle,
    output logic [sprr_pkg::OUT_QUEUE_WIDTH-1:0]  out_served_queue
);
    sprr_pkg::cmd_t  cmd;
    sprr_pkg::stat_t stat;

    // sequencing
    sprr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // queues and scheduling
    sprr_dp #(
        .NUM_QUEUES   (NUM_QUEUES),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .action        (in_action),
        .tag_present   (in_tag_present),
        .priority_req  (in_priority_req),
        .packet_handle (in_packet_handle),
        .cmd           (cmd),
        .stat          (stat),
        .accepted      (out_accepted),
        .packet_valid  (out_packet_valid),
        .out_handle    (out_out_handle),
        .served_queue  (out_served_queue)
    );
endmodule
`default_nettype wire

// ===== bench/strict_priority_plus_round_robin_queue_tb.sv =====
// strict_priority_plus_round_robin_queue_tb: self-checking bench for the packet scheduler
// depends on sprr_pkg, sprr_if and the scheduler rtl; words checked against a local queue model
`default_nettype none
module strict_priority_plus_round_robin_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NQ    = sprr_pkg::NUM_QUEUES_DEF;
    localparam int DEPTH = sprr_pkg::QUEUE_DEPTH_DEF;

    typedef struct packed {
        logic        action;
        logic        tag_present;
        logic [15:0] priority_req;
        logic [15:0] packet_handle;
    } sched_req_t;

    typedef struct packed {
        logic        accepted;
        logic        packet_valid;
        logic [15:0] out_handle;
        logic [5:0]  served_queue;
    } sched_rsp_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [sprr_pkg::CFG_WIDTH-1:0] cfg_wdata;

    sprr_if #(.payload_t(sched_req_t)) req_ch ();
    sprr_if #(.payload_t(sched_rsp_t)) rsp_ch ();

    // scheduler model state
    logic [15:0] q_store [NQ][DEPTH];
    logic [3:0]  q_head [NQ];
    logic [3:0]  q_tail [NQ];
    logic [4:0]  q_fill [NQ];
    logic [NQ-1:0] busy_map;
    logic [5:0]  rr_ptr;
    logic [6:0]  qiu_reg;

    sched_rsp_t pending_rsp [$];
    int err_count;
    bit steady_flow;
    int ready_hold;

    strict_priority_plus_round_robin_queue u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (req_ch.valid),
        .in_ready         (req_ch.ready),
        .in_action        (req_ch.payload.action),
        .in_tag_present   (req_ch.payload.tag_present),
        .in_priority_req  (req_ch.payload.priority_req),
        .in_packet_handle (req_ch.payload.packet_handle),
        .out_valid        (rsp_ch.valid),
        .out_ready        (rsp_ch.ready),
        .out_accepted     (rsp_ch.payload.accepted),
        .out_packet_valid (rsp_ch.payload.packet_valid),
        .out_out_handle   (rsp_ch.payload.out_handle),
        .out_served_queue (rsp_ch.payload.served_queue)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("strict_priority_plus_round_robin_queue_tb: done, errors");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 96) return $urandom_range(3, 8);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [6:0] active_count();
        if (qiu_reg == 7'd0) return 7'd1;
        if (qiu_reg > NQ) return 7'(NQ);
        return qiu_reg;
    endfunction

    function automatic logic [15:0] take_head(int q);
        logic [15:0] h;
        h = q_store[q][q_head[q]];
        q_head[q] = q_head[q] + 4'd1;
        q_fill[q] = q_fill[q] - 5'd1;
        if (q_fill[q] == 5'd0) busy_map[q] = 1'b0;
        return h;
    endfunction

    // expected response for one accepted request word
    function automatic sched_rsp_t schedule_word(sched_req_t w);
        sched_rsp_t r;
        logic [6:0] n;
        int q;
        int found;
        r = '0;
        q = 0;
        found = -1;
        if (w.action == sprr_pkg::ACTION_ENQ)
        begin
            n = active_count();
            if (w.tag_present) q = (w.priority_req >= n) ? n - 1 : w.priority_req;
            if (q_fill[q] < DEPTH)
            begin
                q_store[q][q_tail[q]] = w.packet_handle;
                q_tail[q] = q_tail[q] + 4'd1;
                q_fill[q] = q_fill[q] + 5'd1;
                busy_map[q] = 1'b1;
                r.accepted = 1'b1;
            end
        end
        else
        begin
            if (busy_map[0])
            begin
                r.out_handle = take_head(0);
                r.packet_valid = 1'b1;
            end
            else
            begin
                for (int i = int'(rr_ptr) + 1; i < NQ && found < 0; i++)
                    if (busy_map[i]) found = i;
                for (int i = 1; i <= int'(rr_ptr) && found < 0; i++)
                    if (busy_map[i]) found = i;
                if (found > 0)
                begin
                    rr_ptr = 6'(found);
                    q = found;
                    r.out_handle = take_head(q);
                    r.packet_valid = 1'b1;
                end
                else
                begin
                    rr_ptr = 6'd0;
                end
            end
        end
        r.served_queue = 6'(q);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        err_count++;
        $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    // send one request word and record its expected response
    task automatic send_word(logic act, logic tag, logic [15:0] pri, logic [15:0] hdl);
        sched_req_t w;
        int g;
        w = '{action: act, tag_present: tag, priority_req: pri, packet_handle: hdl};
        req_ch.payload <= w;
        req_ch.valid <= 1'b1;
        do @(posedge clk); while (!req_ch.ready);
        pending_rsp.insert(pending_rsp.size(), schedule_word(w));
        g = gap_len();
        if (g > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic enqueue(logic tag, logic [15:0] pri, logic [15:0] hdl);
        send_word(sprr_pkg::ACTION_ENQ, tag, pri, hdl);
    endtask

    task automatic dequeue();
        send_word(sprr_pkg::ACTION_DEQ, 1'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // drain outstanding responses and let the block go idle, ahead of a register write
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_qiu(logic [6:0] v);
        wait_idle();
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge clk);
        qiu_reg = v;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // response side: random stalls, compare every accepted word
    always @(posedge clk)
    begin
        sched_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                report_mismatch("unexpected word", 32'(rsp_ch.payload), 32'd0);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_ch.payload.accepted !== want.accepted)
                    report_mismatch("accepted", rsp_ch.payload.accepted, want.accepted);
                if (rsp_ch.payload.packet_valid !== want.packet_valid)
                    report_mismatch("packet_valid", rsp_ch.payload.packet_valid,
                                    want.packet_valid);
                if (rsp_ch.payload.out_handle !== want.out_handle)
                    report_mismatch("out_handle", rsp_ch.payload.out_handle, want.out_handle);
                if (rsp_ch.payload.served_queue !== want.served_queue)
                    report_mismatch("served_queue", rsp_ch.payload.served_queue,
                                    want.served_queue);
            end
        end
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 99) < 25) ready_hold <= gap_len();
        end
    end

    // strict queue 0, priority folding, full queue, empty dequeue
    task automatic test_directed();
        enqueue(1'b1, 16'd5, 16'hFFFF);
        enqueue(1'b1, 16'd3, 16'h0000);
        enqueue(1'b0, 16'hFFFF, 16'h1234);
        enqueue(1'b1, 16'hFFFF, 16'hA5A5);
        enqueue(1'b1, 16'd63, 16'h5A5A);
        enqueue(1'b1, 16'd64, 16'h8001);
        repeat (7) dequeue();
        for (int i = 0; i < DEPTH + 2; i++) enqueue(1'b1, 16'd9, 16'(i * 257));
        repeat (3) dequeue();
        dequeue();
    endtask

    // register at its extremes; items left in higher queues after a shrink
    task automatic test_register();
        enqueue(1'b1, 16'd40, 16'hBEEF);
        enqueue(1'b1, 16'd2, 16'hCAFE);
        write_qiu(7'd1);
        enqueue(1'b1, 16'd7, 16'h0F0F);
        enqueue(1'b0, 16'd0, 16'hF0F0);
        repeat (5) dequeue();
        write_qiu(7'd0);
        enqueue(1'b1, 16'hFFFF, 16'h1111);
        dequeue();
        write_qiu(7'd127);
        enqueue(1'b1, 16'd100, 16'h2222);
        enqueue(1'b1, 16'd62, 16'h3333);
        repeat (3) dequeue();
    endtask

    // mixed traffic: priorities mostly within the queues in use
    task automatic test_random(logic [6:0] qiu, int count, int deq_pct);
        int p;
        write_qiu(qiu);
        for (int k = 0; k < count; k++)
        begin
            steady_flow = (k % 60) >= 48;
            p = $urandom_range(0, 99);
            if (p < deq_pct)
            begin
                dequeue();
            end
            else if (p < deq_pct + 8)
            begin
                enqueue(1'($urandom), 16'($urandom), 16'($urandom));
            end
            else
            begin
                enqueue($urandom_range(0, 9) != 0,
                        16'($urandom_range(0, (qiu == 0 ? 1 : qiu) + 1)), 16'($urandom));
            end
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        ready_hold = 0;
        err_count = 0;
        steady_flow = 1'b0;
        for (int q = 0; q < NQ; q++)
        begin
            q_head[q] = '0;
            q_tail[q] = '0;
            q_fill[q] = '0;
        end
        busy_map = '0;
        rr_ptr = '0;
        qiu_reg = 7'd64;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register();
        test_random(7'd64, 120, 40);
        test_random(7'd4, 130, 45);
        test_random(7'd1, 80, 45);
        test_random(7'(2 + $urandom_range(0, 10)), 130, 50);
        test_random(7'd90, 130, 50);

        wait_idle();
        if (err_count == 0)
            $display("strict_priority_plus_round_robin_queue_tb: done, clean");
        else
            $display("strict_priority_plus_round_robin_queue_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/sprr_pkg.sv
hw/rtl/sprr_if.sv
hw/rtl/sprr_ram.sv
hw/rtl/sprr_ctrl.sv
hw/rtl/sprr_dp.sv
hw/rtl/strict_priority_plus_round_robin_queue.sv
bench/strict_priority_plus_round_robin_queue_tb.sv
